@@ hw/rtl/smps_pkg.sv @@
// Shared constants for the sliding median point stability block.
// No dependencies; referenced by the interfaces and imported by every module.
`timescale 1ns / 1ps
package smps_pkg;
  localparam int WINDOW_MAX_DEF = 128;
  localparam int COORD_BITS_DEF = 20;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_RADIUS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_LIMIT  = 2'd2;

  localparam logic [7:0]  LENGTH_RESET = 8'd100;
  localparam logic [11:0] RADIUS_RESET = 12'd80;
  localparam logic [7:0]  LIMIT_RESET  = 8'd60;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;
endpackage

@@ hw/rtl/smps_ifs.sv @@
// Valid/ready channel interfaces: point input, result output, config write.
// Depends on smps_pkg.
`timescale 1ns / 1ps
interface smps_in_if #(parameter int COORD_BITS = smps_pkg::COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic                         valid_req;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  modport source (output valid, valid_req, point_x, point_y, input ready);
  modport sink (input valid, valid_req, point_x, point_y, output ready);
endinterface

interface smps_out_if #(parameter int COORD_BITS = smps_pkg::COORD_BITS_DEF) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] median_x;
  logic signed [COORD_BITS-1:0] median_y;
  logic [7:0]                   stable_count;
  logic                         found;
  logic signed [COORD_BITS-1:0] vanish_x;
  logic signed [COORD_BITS-1:0] vanish_y;
  modport source (output valid, median_x, median_y, stable_count, found, vanish_x, vanish_y,
                  input ready);
  modport sink (input valid, median_x, median_y, stable_count, found, vanish_x, vanish_y,
                output ready);
endinterface

interface smps_cfg_if ();
  logic                                   valid;
  logic                                   ready;
  logic [smps_pkg::CFG_INDEX_BITS-1:0]    index;
  logic [smps_pkg::CFG_DATA_BITS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/smps_front.sv @@
// Front end: accepts input items, drops invalid ones, queues valid points.
// Depends on smps_pkg and smps_in_if.
`timescale 1ns / 1ps
module smps_front #(
  parameter int COORD_BITS = smps_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  smps_in_if.sink                      points,
  output logic                         q_valid,
  output logic signed [COORD_BITS-1:0] q_x,
  output logic signed [COORD_BITS-1:0] q_y,
  input  logic                         q_pop
);
  import smps_pkg::*;

  logic signed [COORD_BITS-1:0] ent_x [2];
  logic signed [COORD_BITS-1:0] ent_y [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign points.ready = (cnt != 2'd2);
  assign push = points.valid && points.ready && points.valid_req;
  assign pop  = q_pop && (cnt != 2'd0);
  assign q_valid = (cnt != 2'd0);
  assign q_x = ent_x[rd_ptr];
  assign q_y = ent_y[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_x[wr_ptr] <= points.point_x;
      ent_y[wr_ptr] <= points.point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

@@ hw/rtl/smps_back.sv @@
// Back end: window memories, rank search for the medians, stability tracking
// and the result register. Depends on smps_pkg, smps_out_if, smps_cfg_if.
`timescale 1ns / 1ps
module smps_back #(
  parameter int WINDOW_MAX = smps_pkg::WINDOW_MAX_DEF,
  parameter int COORD_BITS = smps_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  logic signed [COORD_BITS-1:0] q_x,
  input  logic signed [COORD_BITS-1:0] q_y,
  output logic                         q_pop,
  smps_cfg_if.sink                     cfg,
  smps_out_if.source                   results
);
  import smps_pkg::*;

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int FW = $clog2(WINDOW_MAX + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_MAX);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CAND  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_EVAL1 = 3'd5;
  localparam logic [2:0] ST_EVAL2 = 3'd6;

  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [FW-1:0] b);
    logic [FW:0] s;
    s = (FW+1)'(a) + (FW+1)'(b);
    if (s >= (FW+1)'(WINDOW_MAX)) s = s - (FW+1)'(WINDOW_MAX);
    return s[AW-1:0];
  endfunction

  logic signed [COORD_BITS-1:0] mem_x [WINDOW_MAX];
  logic signed [COORD_BITS-1:0] mem_y [WINDOW_MAX];

  logic [7:0]  len_reg;
  logic [11:0] radius;
  logic [7:0]  limit;

  logic [2:0]    state;
  logic [AW-1:0] oldest;
  logic [FW-1:0] fill;
  logic [FW-1:0] k;
  logic [AW-1:0] ci_addr;
  logic [AW-1:0] cj_addr;
  logic [FW-1:0] j_cnt;
  logic          sw_v;
  logic signed [COORD_BITS-1:0] cand_x, cand_y, bx, by;
  logic [FW-1:0] less_x, eq_x, less_y, eq_y;
  logic          got_x, got_y;
  logic signed [COORD_BITS-1:0] med_x, med_y;
  logic signed [COORD_BITS-1:0] anchor_x, anchor_y;
  logic [7:0]    good;
  logic          found_flag;
  logic signed [COORD_BITS-1:0] latched_x, latched_y;
  logic [23:0]   sq_x, sq_y, rr;
  logic          near_pre;
  logic          out_valid;
  logic signed [COORD_BITS-1:0] out_mx, out_my, out_vx, out_vy;
  logic [7:0]    out_cnt;
  logic          out_found;

  logic [FW-1:0] len_eff;
  logic          full;
  logic [AW-1:0] o1, slot, oldest_next;
  logic [FW-1:0] f1, f2, fill_next;
  logic          hit_x, hit_y;
  logic signed [COORD_BITS:0] dx_s, dy_s;
  logic [COORD_BITS:0] dx, dy;
  logic          close;
  logic [7:0]    good_next;
  logic          out_free;

  always_comb begin
    if (len_reg == 8'd0) len_eff = FW'(1);
    else if (int'(len_reg) > WINDOW_MAX) len_eff = FILL_MAX;
    else len_eff = FW'(len_reg);
    full = (fill == FILL_MAX);
    o1 = full ? add_wrap(oldest, FW'(1)) : oldest;
    f1 = full ? FILL_MAX - FW'(1) : fill;
    slot = add_wrap(o1, f1);
    f2 = f1 + FW'(1);
    if (f2 > len_eff) begin
      oldest_next = add_wrap(o1, f2 - len_eff);
      fill_next = len_eff;
    end else begin
      oldest_next = o1;
      fill_next = f2;
    end
  end

  assign hit_x = !got_x && ((FW+1)'(less_x) <= (FW+1)'(k))
                 && ((FW+1)'(k) < (FW+1)'(less_x) + (FW+1)'(eq_x));
  assign hit_y = !got_y && ((FW+1)'(less_y) <= (FW+1)'(k))
                 && ((FW+1)'(k) < (FW+1)'(less_y) + (FW+1)'(eq_y));

  assign dx_s = (COORD_BITS+1)'(med_x) - (COORD_BITS+1)'(anchor_x);
  assign dy_s = (COORD_BITS+1)'(med_y) - (COORD_BITS+1)'(anchor_y);
  assign dx = dx_s[COORD_BITS] ? (COORD_BITS+1)'(-dx_s) : (COORD_BITS+1)'(dx_s);
  assign dy = dy_s[COORD_BITS] ? (COORD_BITS+1)'(-dy_s) : (COORD_BITS+1)'(dy_s);

  assign close = near_pre && ((25'(sq_x) + 25'(sq_y)) < 25'(rr));
  assign good_next = close ? ((good == COUNT_MAX) ? COUNT_MAX : good + 8'd1) : 8'd0;
  assign out_free = !out_valid || results.ready;
  assign q_pop = (state == ST_IDLE) && q_valid;

  assign cfg.ready = 1'b1;
  assign results.valid        = out_valid;
  assign results.median_x     = out_mx;
  assign results.median_y     = out_my;
  assign results.stable_count = out_cnt;
  assign results.found        = out_found;
  assign results.vanish_x     = out_vx;
  assign results.vanish_y     = out_vy;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_x[slot] <= q_x;
      mem_y[slot] <= q_y;
    end
    if (state == ST_CAND) begin
      cand_x <= mem_x[ci_addr];
      cand_y <= mem_y[ci_addr];
    end
    if (state == ST_SWEEP) begin
      bx <= mem_x[cj_addr];
      by <= mem_y[cj_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg <= LENGTH_RESET;
      radius  <= RADIUS_RESET;
      limit   <= LIMIT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WINDOW_LENGTH: len_reg <= cfg.data[7:0];
        REG_STABLE_RADIUS: radius  <= cfg.data[11:0];
        REG_STABLE_LIMIT:  limit   <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      oldest     <= '0;
      fill       <= '0;
      anchor_x   <= '0;
      anchor_y   <= '0;
      good       <= '0;
      found_flag <= 1'b0;
      latched_x  <= '0;
      latched_y  <= '0;
      out_valid  <= 1'b0;
      sw_v       <= 1'b0;
      got_x      <= 1'b0;
      got_y      <= 1'b0;
    end else begin
      sw_v <= (state == ST_SWEEP);
      if ((state == ST_EVAL2) && out_free) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
      if (sw_v) begin
        if (bx < cand_x) less_x <= less_x + FW'(1);
        else if (bx == cand_x) eq_x <= eq_x + FW'(1);
        if (by < cand_y) less_y <= less_y + FW'(1);
        else if (by == cand_y) eq_y <= eq_y + FW'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            oldest  <= oldest_next;
            fill    <= fill_next;
            ci_addr <= oldest_next;
            k       <= fill_next >> 1;
            got_x   <= 1'b0;
            got_y   <= 1'b0;
            state   <= ST_CAND;
          end
        end
        ST_CAND: begin
          cj_addr <= oldest;
          j_cnt   <= '0;
          less_x  <= '0;
          eq_x    <= '0;
          less_y  <= '0;
          eq_y    <= '0;
          state   <= ST_SWEEP;
        end
        ST_SWEEP: begin
          cj_addr <= add_wrap(cj_addr, FW'(1));
          j_cnt   <= j_cnt + FW'(1);
          if (j_cnt == fill - FW'(1)) state <= ST_DRAIN;
        end
        ST_DRAIN: state <= ST_CHECK;
        ST_CHECK: begin
          if (hit_x) begin
            got_x <= 1'b1;
            med_x <= cand_x;
          end
          if (hit_y) begin
            got_y <= 1'b1;
            med_y <= cand_y;
          end
          if ((got_x || hit_x) && (got_y || hit_y)) begin
            state <= ST_EVAL1;
          end else begin
            ci_addr <= add_wrap(ci_addr, FW'(1));
            state   <= ST_CAND;
          end
        end
        ST_EVAL1: begin
          near_pre <= (dx < (COORD_BITS+1)'(radius)) && (dy < (COORD_BITS+1)'(radius));
          sq_x  <= dx[11:0] * dx[11:0];
          sq_y  <= dy[11:0] * dy[11:0];
          rr    <= radius * radius;
          state <= ST_EVAL2;
        end
        ST_EVAL2: begin
          if (out_free) begin
            good <= good_next;
            if (!close) begin
              anchor_x <= med_x;
              anchor_y <= med_y;
            end
            out_mx    <= med_x;
            out_my    <= med_y;
            out_cnt   <= good_next;
            if (good_next > limit) begin
              found_flag <= 1'b1;
              latched_x  <= med_x;
              latched_y  <= med_y;
              out_found  <= 1'b1;
              out_vx     <= med_x;
              out_vy     <= med_y;
            end else begin
              out_found  <= found_flag;
              out_vx     <= latched_x;
              out_vy     <= latched_y;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ hw/rtl/sliding_median_point_stability_core.sv @@
// Sliding median of projected points with stability detection.
// The rank search tries window entries one at a time as candidates, each against
// all n points in the window, until both medians are found (1 to n candidates).
// The back end takes a new point only once idle again; two more points queue ahead.
// Synchronous reset clears window bookkeeping, anchor, count, found and latch.
// Depends on smps_pkg, smps_ifs, smps_front, smps_back.
`timescale 1ns / 1ps
module sliding_median_point_stability_core #(
  parameter int WINDOW_MAX = smps_pkg::WINDOW_MAX_DEF,
  parameter int COORD_BITS = smps_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  smps_in_if.sink     points,
  smps_out_if.source  results,
  smps_cfg_if.sink    cfg
);
  import smps_pkg::*;

  logic                         q_valid;
  logic                         q_pop;
  logic signed [COORD_BITS-1:0] q_x;
  logic signed [COORD_BITS-1:0] q_y;

  smps_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .q_valid (q_valid),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_pop   (q_pop)
  );

  smps_back #(.WINDOW_MAX(WINDOW_MAX), .COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_x     (q_x),
    .q_y     (q_y),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .results (results)
  );
endmodule
